FILE: src/tct_pkg.sv
// Package for the command line tokenizer: request and result structs,
// tokenizer state type, phase and quote enums, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_MOD = 2'd2;
	localparam logic [1:0] OP_DEL = 2'd3;

	localparam logic [1:0] ST_BUSY    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_NO_KEY  = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic [1:0] TOK_OP  = 2'd0;
	localparam logic [1:0] TOK_KEY = 2'd1;
	localparam logic [1:0] TOK_VAL = 2'd2;

	localparam logic [1:0] TOTAL_NONE  = 2'd0;
	localparam logic [1:0] TOTAL_SHORT = 2'd2;
	localparam logic [1:0] TOTAL_FULL  = 2'd3;

	localparam logic [2:0] OP_LEN_MAX = 3'd4;
	localparam logic [2:0] OP_LEN_WORD = 3'd3;

	localparam logic [23:0] OP_WORDS [4] = '{
		24'h534554,	// SET
		24'h474554,	// GET
		24'h4D4F44,	// MOD
		24'h44454C	// DEL
	};

	typedef enum logic [2:0] {
		PH_OP_LEAD  = 3'd0,
		PH_OP       = 3'd1,
		PH_KEY_LEAD = 3'd2,
		PH_KEY      = 3'd3,
		PH_VAL_LEAD = 3'd4,
		PH_VAL      = 3'd5,
		PH_DONE     = 3'd6,
		PH_REFUSED  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} cmd_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic [1:0] token_number;
		logic [1:0] op_code;
		logic [1:0] line_status;
		logic [1:0] token_total;
	} tok_t;

	typedef struct packed {
		phase_t      phase;
		logic [23:0] op_chars;
		logic [2:0]  op_length;
		logic [1:0]  op_kind;
		quote_t      quote_kind;
		logic        escape_pending;
		logic [1:0]  outcome;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:          PH_OP_LEAD,
		op_chars:       24'd0,
		op_length:      3'd0,
		op_kind:        OP_SET,
		quote_kind:     Q_NONE,
		escape_pending: 1'b0,
		outcome:        ST_BUSY
	};

	function automatic logic is_short_op(logic [1:0] k);
		return (k == OP_GET) || (k == OP_DEL);
	endfunction

endpackage

`default_nettype wire

FILE: src/tct_step.sv
// Next-state and result logic for one byte of the command line.
// Depends on tct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tct_step (
	input  wire tct_pkg::state_t cur,
	input  wire tct_pkg::cmd_t   cmd,
	output tct_pkg::state_t      nxt,
	output tct_pkg::tok_t        res
);
	import tct_pkg::*;

	logic [7:0] c;
	logic       last;
	logic       hit;
	logic [1:0] hit_idx;
	logic       body;
	state_t     n;

	assign c    = cmd.char_in;
	assign last = cmd.line_end;

	always_comb begin
		hit     = 1'b0;
		hit_idx = OP_SET;
		for (int i = 0; i < 4; i++) begin
			if (!hit && cur.op_length == OP_LEN_WORD && cur.op_chars == OP_WORDS[i]) begin
				hit     = 1'b1;
				hit_idx = 2'(i);
			end
		end
	end

	always_comb begin
		n    = cur;
		body = 1'b0;
		res  = '0;
		case (cur.phase)
			PH_OP_LEAD, PH_OP: begin
				if (c == CH_SPACE) begin
					if (cur.phase == PH_OP) begin
						if (hit) begin
							n.op_kind = hit_idx;
							n.phase   = PH_KEY_LEAD;
						end else begin
							n.phase   = PH_REFUSED;
							n.outcome = ST_UNKNOWN;
						end
					end
				end else begin
					n.phase = PH_OP;
					if (cur.op_length < OP_LEN_MAX) begin
						if (cur.op_length < OP_LEN_WORD)
							n.op_chars = {cur.op_chars[15:0], c};
						n.op_length = cur.op_length + 3'd1;
					end
					res.char_valid   = 1'b1;
					res.token_number = TOK_OP;
					res.char_out     = c;
				end
			end
			PH_KEY_LEAD, PH_KEY: begin
				if (c == CH_SPACE) begin
					if (cur.phase == PH_KEY)
						n.phase = is_short_op(cur.op_kind) ? PH_DONE : PH_VAL_LEAD;
				end else begin
					n.phase          = PH_KEY;
					res.char_valid   = 1'b1;
					res.token_number = TOK_KEY;
					res.char_out     = c;
				end
			end
			PH_VAL_LEAD, PH_VAL: begin
				if (cur.escape_pending) begin
					n.escape_pending = 1'b0;
					res.char_valid   = 1'b1;
					res.token_number = TOK_VAL;
					res.char_out     = c;
				end else begin
					body = 1'b1;
					if (cur.phase == PH_VAL_LEAD) begin
						if (c == CH_SPACE) begin
							body = 1'b0;
						end else begin
							n.phase = PH_VAL;
							if (c == CH_DQUOTE) begin
								n.quote_kind = Q_DOUBLE;
								body         = 1'b0;
							end else if (c == CH_SQUOTE) begin
								n.quote_kind = Q_SINGLE;
								body         = 1'b0;
							end else begin
								n.quote_kind = Q_NONE;
							end
						end
					end
					if (body) begin
						if (c == CH_BSLASH) begin
							if (last) begin
								res.char_valid   = 1'b1;
								res.token_number = TOK_VAL;
								res.char_out     = CH_BSLASH;
							end else begin
								n.escape_pending = 1'b1;
							end
						end else if ((n.quote_kind == Q_DOUBLE && c == CH_DQUOTE) ||
								(n.quote_kind == Q_SINGLE && c == CH_SQUOTE)) begin
							n.phase = PH_DONE;
						end else begin
							res.char_valid   = 1'b1;
							res.token_number = TOK_VAL;
							res.char_out     = c;
						end
					end
				end
			end
			default: begin
			end
		endcase

		res.op_code     = n.op_kind;
		res.line_status = n.outcome;
		res.token_total = TOTAL_NONE;
		if (last) begin
			if (n.phase == PH_REFUSED) begin
				res.line_status = ST_UNKNOWN;
			end else if (n.phase == PH_OP_LEAD || n.phase == PH_OP) begin
				res.line_status = ST_NO_KEY;
			end else begin
				res.line_status = ST_OK;
				res.token_total = is_short_op(n.op_kind) ? TOTAL_SHORT : TOTAL_FULL;
			end
		end

		nxt = last ? STATE_RESET : n;
	end

endmodule

`default_nettype wire

FILE: src/tct_out_reg.sv
// Result register with valid/ready handshake; takes a new result
// in the same cycle that the held one is taken. Depends on tct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tct_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  wire tct_pkg::tok_t din,
	output logic               free,
	output logic               tok_valid,
	input  wire                tok_ready,
	output tct_pkg::tok_t      tok
);
	import tct_pkg::*;

	logic valid_q;
	tok_t data_q;

	assign free      = !valid_q || tok_ready;
	assign tok_valid = valid_q;
	assign tok       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= din;
		end
	end

endmodule

`default_nettype wire

FILE: src/text_command_tokenizer_core.sv
// Command line tokenizer top level: one byte per request, one result each.
// A request's result is registered and shown in the cycle after it is accepted.
// Throughput: one byte per clock unless results stall; the single tokenizer state
// register is updated in the cycle a byte is accepted and feeds the next byte.
// Reset: tokenizer state returns to skipping leading spaces before the op,
// and the result register is emptied. Depends on tct_pkg, tct_step, tct_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module text_command_tokenizer_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  wire tct_pkg::cmd_t cmd,
	output logic               tok_valid,
	input  wire                tok_ready,
	output tct_pkg::tok_t      tok
);
	import tct_pkg::*;

	state_t state_q;
	state_t state_nxt;
	tok_t   step_res;
	logic   accept;

	assign accept = cmd_valid && cmd_ready;

	tct_step u_step (
		.cur (state_q),
		.cmd (cmd),
		.nxt (state_nxt),
		.res (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	tct_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd_valid),
		.din       (step_res),
		.free      (cmd_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

endmodule

`default_nettype wire

FILE: tb/sv/text_command_tokenizer_core_tb.sv
// Self-checking testbench for text_command_tokenizer_core: directed command lines,
// then random lines, with a byte-level token predictor and random backpressure.
// Depends on tct_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module text_command_tokenizer_core_tb;
	import tct_pkg::*;

	localparam int RAND_ITEMS  = 1900;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		cmd_t req;
		logic typed;
		tok_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic tok_valid;
	logic tok_ready = 1'b0;
	tok_t tok;

	state_t     line_st;
	tok_t       tokens_due[$];
	logic [7:0] line_buf[$];
	dir_row_t   dir_rows[$];
	int         errors = 0;
	int         sent = 0;
	int         cycles = 0;
	int         idle_left = 0;
	bit         quiet = 1'b0;
	bit         hold_req = 1'b0;

	text_command_tokenizer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void add_op_char(input logic [7:0] b);
		if (line_st.op_length < OP_LEN_MAX) begin
			if (line_st.op_length < OP_LEN_WORD)
				line_st.op_chars = {line_st.op_chars[15:0], b};
			line_st.op_length = line_st.op_length + 3'd1;
		end
	endfunction

	// one byte in, one token result out; advances line_st
	function automatic tok_t tokenize_byte(input cmd_t c);
		tok_t       r;
		logic       emit;
		logic [1:0] tnum;
		logic [7:0] ch;
		logic       hit;
		logic       skip;
		logic       short_op;
		int         k;
		emit = 1'b0;
		tnum = TOK_OP;
		ch = 8'h00;
		short_op = (line_st.op_kind == OP_GET) || (line_st.op_kind == OP_DEL);
		case (line_st.phase)
			PH_OP_LEAD: begin
				if (c.char_in != CH_SPACE) begin
					line_st.phase = PH_OP;
					add_op_char(c.char_in);
					emit = 1'b1;
					ch = c.char_in;
				end
			end
			PH_OP: begin
				if (c.char_in == CH_SPACE) begin
					hit = 1'b0;
					if (line_st.op_length == OP_LEN_WORD) begin
						for (k = 0; k < 4; k++) begin
							if (line_st.op_chars == OP_WORDS[k]) begin
								hit = 1'b1;
								line_st.op_kind = k[1:0];
							end
						end
					end
					if (hit) begin
						line_st.phase = PH_KEY_LEAD;
					end else begin
						line_st.phase = PH_REFUSED;
						line_st.outcome = ST_UNKNOWN;
					end
				end else begin
					add_op_char(c.char_in);
					emit = 1'b1;
					ch = c.char_in;
				end
			end
			PH_KEY_LEAD, PH_KEY: begin
				if (c.char_in == CH_SPACE) begin
					if (line_st.phase == PH_KEY)
						line_st.phase = short_op ? PH_DONE : PH_VAL_LEAD;
				end else begin
					line_st.phase = PH_KEY;
					emit = 1'b1;
					tnum = TOK_KEY;
					ch = c.char_in;
				end
			end
			PH_VAL_LEAD, PH_VAL: begin
				if (line_st.escape_pending) begin
					line_st.escape_pending = 1'b0;
					emit = 1'b1;
					tnum = TOK_VAL;
					ch = c.char_in;
				end else begin
					skip = 1'b0;
					if (line_st.phase == PH_VAL_LEAD) begin
						if (c.char_in == CH_SPACE) begin
							skip = 1'b1;
						end else begin
							line_st.phase = PH_VAL;
							if (c.char_in == CH_DQUOTE) begin
								line_st.quote_kind = Q_DOUBLE;
								skip = 1'b1;
							end else if (c.char_in == CH_SQUOTE) begin
								line_st.quote_kind = Q_SINGLE;
								skip = 1'b1;
							end else begin
								line_st.quote_kind = Q_NONE;
							end
						end
					end
					if (!skip) begin
						if (c.char_in == CH_BSLASH) begin
							if (c.line_end) begin
								emit = 1'b1;
								tnum = TOK_VAL;
								ch = CH_BSLASH;
							end else begin
								line_st.escape_pending = 1'b1;
							end
						end else if ((line_st.quote_kind == Q_DOUBLE && c.char_in == CH_DQUOTE) ||
								(line_st.quote_kind == Q_SINGLE && c.char_in == CH_SQUOTE)) begin
							line_st.phase = PH_DONE;
						end else begin
							emit = 1'b1;
							tnum = TOK_VAL;
							ch = c.char_in;
						end
					end
				end
			end
			default: ;
		endcase

		r.char_out     = ch;
		r.char_valid   = emit;
		r.token_number = tnum;
		r.op_code      = line_st.op_kind;
		r.line_status  = line_st.outcome;
		r.token_total  = TOTAL_NONE;
		if (c.line_end) begin
			if (line_st.phase == PH_REFUSED) begin
				r.line_status = ST_UNKNOWN;
			end else if (line_st.phase == PH_OP_LEAD || line_st.phase == PH_OP) begin
				r.line_status = ST_NO_KEY;
			end else begin
				r.line_status = ST_OK;
				r.token_total = ((line_st.op_kind == OP_GET) || (line_st.op_kind == OP_DEL)) ?
						TOTAL_SHORT : TOTAL_FULL;
			end
			line_st = STATE_RESET;
		end
		return r;
	endfunction

	function automatic dir_row_t row(input logic [7:0] ch, input logic last, input logic typed,
			input tok_t want);
		dir_row_t d;
		d.req.char_in = ch;
		d.req.line_end = last;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return CH_DQUOTE;
			1: return CH_SQUOTE;
			2, 3: return CH_BSLASH;
			4: return CH_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic compare_token(input tok_t got, input tok_t want);
		if (got.char_out !== want.char_out)
			report_mismatch($sformatf("char_out got %h want %h", got.char_out, want.char_out));
		if (got.char_valid !== want.char_valid)
			report_mismatch($sformatf("char_valid got %b want %b", got.char_valid,
					want.char_valid));
		if (got.token_number !== want.token_number)
			report_mismatch($sformatf("token_number got %0d want %0d", got.token_number,
					want.token_number));
		if (got.op_code !== want.op_code)
			report_mismatch($sformatf("op_code got %0d want %0d", got.op_code, want.op_code));
		if (got.line_status !== want.line_status)
			report_mismatch($sformatf("line_status got %0d want %0d", got.line_status,
					want.line_status));
		if (got.token_total !== want.token_total)
			report_mismatch($sformatf("token_total got %0d want %0d", got.token_total,
					want.token_total));
	endtask

	// mostly well-formed lines with random content; some cut short, some noise
	task automatic gen_line();
		int         kind;
		int         n;
		int         i;
		int         q;
		logic [7:0] b;
		line_buf.delete();
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			n = $urandom_range(1, 6);
			repeat (n) line_buf.push_back(pick_byte());
		end else begin
			repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 5)) line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
			end else begin
				n = $urandom_range(0, 3);
				for (i = 0; i < 3; i++)
					line_buf.push_back(OP_WORDS[n][8*(2-i) +: 8]);
			end
			line_buf.push_back(CH_SPACE);
			repeat ($urandom_range(0, 4)) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_SPACE)
					b = 8'h5F;
				line_buf.push_back(b);
			end
			repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
			q = $urandom_range(0, 2);
			if (q == 1)
				line_buf.push_back(CH_DQUOTE);
			else if (q == 2)
				line_buf.push_back(CH_SQUOTE);
			repeat ($urandom_range(0, 6)) line_buf.push_back(pick_byte());
			if (q != 0 && $urandom_range(0, 3) != 0)
				line_buf.push_back(q == 1 ? CH_DQUOTE : CH_SQUOTE);
			repeat ($urandom_range(0, 2)) line_buf.push_back(pick_byte());
			if (kind < 5) begin
				n = $urandom_range(1, line_buf.size());
				while (line_buf.size() > n)
					void'(line_buf.pop_back());
			end
		end
	endtask

	task automatic send_cmd(input cmd_t c, input logic typed, input tok_t want);
		tok_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		pred = tokenize_byte(c);
		tokens_due.push_back(typed ? want : pred);
		sent++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: check, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && tok_ready) begin
				if (tokens_due.size() == 0)
					report_mismatch($sformatf("unexpected request result %h", tok));
				else
					compare_token(tok, tokens_due.pop_front());
			end
			if (hold_req) begin
				hold_req = 1'b0;
				idle_left = LONG_HOLD;
			end
			if (idle_left > 0) begin
				tok_ready <= 1'b0;
				idle_left = idle_left - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				tok_ready <= 1'b0;
				idle_left = $urandom_range(0, 10);
			end else begin
				tok_ready <= 1'b1;
			end
		end
	end

	initial begin
		int   i;
		int   n_dir;
		bit   held;
		bit   paused;
		cmd_t c;
		dir_rows = '{
			row("G", 1'b0, 1'b0, '0),
			row("E", 1'b0, 1'b0, '0),
			row("T", 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b0, 1'b0, '0),
			row("k", 1'b1, 1'b1, '{8'h6B, 1'b1, TOK_KEY, OP_GET, ST_OK, TOTAL_SHORT}),
			// line ends inside the op, on a zero byte
			row(8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, TOK_OP, OP_SET, ST_NO_KEY, TOTAL_NONE}),
			// op too short
			row(8'hFF, 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b1, 1'b1, '{8'h00, 1'b0, TOK_OP, OP_SET, ST_UNKNOWN, TOTAL_NONE}),
			// leading space, op ends on the last byte: empty key
			row(CH_SPACE, 1'b0, 1'b1, '{8'h00, 1'b0, TOK_OP, OP_SET, ST_BUSY, TOTAL_NONE}),
			row("D", 1'b0, 1'b0, '0),
			row("E", 1'b0, 1'b0, '0),
			row("L", 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b1, 1'b1, '{8'h00, 1'b0, TOK_OP, OP_DEL, ST_OK, TOTAL_SHORT}),
			// empty double-quoted value
			row("S", 1'b0, 1'b0, '0),
			row("E", 1'b0, 1'b0, '0),
			row("T", 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b0, 1'b0, '0),
			row("k", 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b0, 1'b0, '0),
			row(CH_DQUOTE, 1'b0, 1'b0, '0),
			row(CH_DQUOTE, 1'b1, 1'b0, '0),
			// open single quote, lone backslash on the last byte
			row("M", 1'b0, 1'b0, '0),
			row("O", 1'b0, 1'b0, '0),
			row("D", 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b0, 1'b0, '0),
			row(8'hFF, 1'b0, 1'b0, '0),
			row(CH_SPACE, 1'b0, 1'b0, '0),
			row(CH_SQUOTE, 1'b0, 1'b0, '0),
			row(CH_BSLASH, 1'b1, 1'b1, '{CH_BSLASH, 1'b1, TOK_VAL, OP_MOD, ST_OK, TOTAL_FULL})
		};
		line_st = STATE_RESET;
		held = 1'b0;
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_rows.size(); i++)
			send_cmd(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		n_dir = sent;

		while (sent < n_dir + RAND_ITEMS) begin
			if (!held && sent >= n_dir + 600) begin
				held = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && sent >= n_dir + 1200) begin
				paused = 1'b1;
				cmd_valid <= 1'b0;
				@(posedge clk);
				while (tokens_due.size() != 0) @(posedge clk);
			end
			if (sent >= n_dir + RAND_ITEMS - 200)
				quiet = 1'b1;
			gen_line();
			for (i = 0; i < line_buf.size(); i++) begin
				c.char_in = line_buf[i];
				c.line_end = (i == line_buf.size() - 1);
				send_cmd(c, 1'b0, '0);
			end
		end
		cmd_valid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && tokens_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/tct_pkg.sv
src/tct_step.sv
src/tct_out_reg.sv
src/text_command_tokenizer_core.sv
tb/sv/text_command_tokenizer_core_tb.sv
